@@ hdl/bmpp_pkg.sv @@
// shared types, constants and helper functions for the button motor power panel
`timescale 1ns / 1ps

package bmpp_pkg;

  // field widths fixed by the panel's interface
  localparam int unsigned CountW    = 4;
  localparam int unsigned TempW     = 8;
  localparam int unsigned LevelW    = 3;
  localparam int unsigned DutyW     = 8;
  localparam int unsigned InDataW   = 16;
  localparam int unsigned OutDataW  = 16;

  // default top speed level
  localparam int unsigned MAX_LEVEL_DEF = 5;

  // pwm duty steps per level and its ceiling
  localparam logic [8:0] PWM_STEP = 9'd50;
  localparam logic [8:0] DUTY_MAX = 9'd255;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_DEBOUNCE  = 1'b0,
    CFG_THRESHOLD = 1'b1
  } cfg_index_e;

  // reset values of the configuration registers
  localparam logic [CountW-1:0] DEBOUNCE_RST  = 4'd5;
  localparam logic [TempW-1:0]  THRESHOLD_RST = 8'd50;

  // saturating count ceiling for the press counters
  localparam logic [CountW-1:0] COUNT_MAX = '1;

  // button actions that fire in one sample tick
  typedef struct packed {
    logic up;
    logic down;
    logic onoff;
    logic dir;
  } bmpp_fire_t;

  // pwm compare value for a given level, saturating
  function automatic logic [DutyW-1:0] duty_of(input logic [LevelW-1:0] level);
    logic [8:0] prod;
    prod = 9'(level) * PWM_STEP;
    if (prod > DUTY_MAX) begin
      prod = DUTY_MAX;
    end
    return prod[DutyW-1:0];
  endfunction

endpackage

@@ hdl/bmpp_debounce.sv @@
// single button press qualifier: counts low samples and fires on release
`timescale 1ns / 1ps

module bmpp_debounce (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         pin_n_i,
  input  logic [bmpp_pkg::CountW-1:0]  debounce_i,
  output logic                         idle_o,
  output logic                         fire_o
);
  import bmpp_pkg::*;

  logic [CountW-1:0] count_q, count_d;
  logic              qual_q, qual_d;
  logic [CountW-1:0] count_inc;

  // saturating count of consecutive low samples
  assign count_inc = (count_q == COUNT_MAX) ? COUNT_MAX : count_q + 1'b1;

  // qualify while held low, fire on the first high sample after a qualified press
  always_comb begin
    if (!pin_n_i) begin
      count_d = count_inc;
      qual_d  = qual_q | (count_inc >= debounce_i);
      fire_o  = 1'b0;
    end else begin
      count_d = '0;
      qual_d  = 1'b0;
      fire_o  = qual_q;
    end
  end

  assign idle_o = (count_q == '0);

  // qualifier state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      qual_q  <= 1'b0;
    end else if (en_i) begin
      count_q <= count_d;
      qual_q  <= qual_d;
    end
  end

endmodule

@@ hdl/bmpp_drive.sv @@
// power level and rotation state with the same-tick action ordering
`timescale 1ns / 1ps

module bmpp_drive #(
  parameter int unsigned MAX_LEVEL = bmpp_pkg::MAX_LEVEL_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  bmpp_pkg::bmpp_fire_t         fire_i,
  output logic [bmpp_pkg::LevelW-1:0]  level_o,
  output logic                         reverse_o,
  output logic [bmpp_pkg::DutyW-1:0]   duty_o
);
  import bmpp_pkg::*;

  localparam logic [LevelW-1:0] LevelTop = LevelW'(MAX_LEVEL);
  localparam logic [LevelW-1:0] LevelOne = LevelW'(1);

  logic [LevelW-1:0] level_q, level_d, level_mid;
  logic              dir_q, dir_d;

  // on/off first, then direction, then up and down on the resulting level
  always_comb begin
    level_mid = level_q;
    if (fire_i.onoff) begin
      level_mid = (level_q == '0) ? LevelOne : '0;
    end
    dir_d   = dir_q ^ fire_i.dir;
    level_d = level_mid;
    if (level_mid != '0) begin
      if (fire_i.up && (level_mid < LevelTop)) begin
        level_d = level_mid + 1'b1;
      end
      if (fire_i.down && (level_d > LevelOne)) begin
        level_d = level_d - 1'b1;
      end
    end
  end

  assign level_o   = level_d;
  assign reverse_o = dir_d;
  assign duty_o    = duty_of(level_d);

  // drive state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      dir_q   <= 1'b0;
    end else if (en_i) begin
      level_q <= level_d;
      dir_q   <= dir_d;
    end
  end

  // level never leaves its range
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LevelTop)
    else $error("power level above top level");

  // state only moves with a sample tick
  a_level_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(level_q) && $stable(dir_q))
    else $error("drive state changed without a tick");

endmodule

@@ hdl/button_motor_power_panel.sv @@
// top level of the button motor power panel: input beat register, qualifiers, result register
`timescale 1ns / 1ps

// One sample tick per input beat gives exactly one result beat. Beats are taken
// every clock while the input register is empty or the result register is free. A
// result is presented once its input beat has been held in the input register and
// then loaded into the result register. While a result waits undrained, the input
// register still takes one more beat. Further beats are held off until the result
// register is free or is drained in the same cycle. Configuration writes are always
// ready and take effect on the next tick processed. Debounce counts are in sample
// ticks, not clock cycles.
module button_motor_power_panel #(
  parameter int unsigned MAX_LEVEL = bmpp_pkg::MAX_LEVEL_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input sample beats
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [0] up_button_n, [1] down_button_n, [2] onoff_button_n,
  // [3] direction_button_n, [11:4] temperature_sample, [15:12] zero
  input  logic [bmpp_pkg::InDataW-1:0]   s_axis_tdata,
  // result beats
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] pwm_duty, [10:8] power_level, [11] reverse_direction,
  // [12] over_temperature, [15:13] zero
  output logic [bmpp_pkg::OutDataW-1:0]  m_axis_tdata,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_index_i,
  input  logic [7:0]                     cfg_data_i
);
  import bmpp_pkg::*;

  logic                  s1_valid_q;
  logic [11:0]           s1_data_q;
  logic                  m_valid_q;
  logic [12:0]           m_data_q;
  logic                  out_free;
  logic                  advance;
  logic [CountW-1:0]     debounce_q;
  logic [TempW-1:0]      threshold_q;
  logic                  owr_up_q, owr_up_d;
  logic                  owr_dn_q, owr_dn_d;
  logic [3:0]            btn_n;
  logic [3:0]            btn_idle;
  logic [3:0]            btn_fire;
  logic [TempW-1:0]      temp;
  bmpp_fire_t            fire;
  logic [LevelW-1:0]     level;
  logic                  reverse;
  logic [DutyW-1:0]      duty;
  logic                  over_temp;

  // handshake: result register frees when empty or drained this cycle
  assign out_free      = !m_valid_q || m_axis_tready;
  assign advance       = s1_valid_q && out_free;
  assign s_axis_tready = !s1_valid_q || out_free;
  assign cfg_ready_o   = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= DEBOUNCE_RST;
      threshold_q <= THRESHOLD_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_DEBOUNCE:  debounce_q  <= cfg_data_i[CountW-1:0];
        CFG_THRESHOLD: threshold_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_data_q <= s_axis_tdata[11:0];
    end
  end

  // button order: up, down, on/off, direction
  assign btn_n = s1_data_q[3:0];
  assign temp  = s1_data_q[11:4];

  // one qualifier per button
  for (genvar b = 0; b < 4; b++) begin : g_btn
    bmpp_debounce u_debounce (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (advance),
      .pin_n_i    (btn_n[b]),
      .debounce_i (debounce_q),
      .idle_o     (btn_idle[b]),
      .fire_o     (btn_fire[b])
    );
  end

  // the other speed button must be released at the start of a press
  assign owr_up_d = (!btn_n[0] && btn_idle[0]) ? btn_n[1] : owr_up_q;
  assign owr_dn_d = (!btn_n[1] && btn_idle[1]) ? btn_n[0] : owr_dn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_up_q <= 1'b0;
      owr_dn_q <= 1'b0;
    end else if (advance) begin
      owr_up_q <= owr_up_d;
      owr_dn_q <= owr_dn_d;
    end
  end

  assign fire.up    = btn_fire[0] & owr_up_d;
  assign fire.down  = btn_fire[1] & owr_dn_d;
  assign fire.onoff = btn_fire[2];
  assign fire.dir   = btn_fire[3];

  // level, rotation and duty
  bmpp_drive #(
    .MAX_LEVEL (MAX_LEVEL)
  ) u_drive (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .fire_i    (fire),
    .level_o   (level),
    .reverse_o (reverse),
    .duty_o    (duty)
  );

  // temperature warning
  assign over_temp = (temp > threshold_q);

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (advance) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      m_data_q <= {over_temp, reverse, level, duty};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'b000, m_data_q};

  // a free result register never stalls the input side
  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_valid_q |-> s_axis_tready)
    else $error("input stalled with result register free");

  // the shown duty always matches the shown level
  a_duty_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (m_data_q[7:0] == duty_of(m_data_q[10:8])))
    else $error("duty does not match level");

  // a result taken with no tick behind it leaves the register empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_axis_tready && !s1_valid_q) |=> !m_valid_q)
    else $error("result repeated after drain");

endmodule

@@ tb/button_motor_power_panel_test.sv @@
// self-checking testbench for the button motor power panel: stream driver, monitors, predictor
`timescale 1ns / 1ps

module button_motor_power_panel_test;

  import bmpp_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned TOP_LEVEL      = MAX_LEVEL_DEF;
  localparam int unsigned DUTY_PER_LEVEL = 50;
  localparam int unsigned DUTY_CEILING   = 255;
  localparam logic [3:0]  ALL_RELEASED   = 4'b1111;

  // button positions inside the active-low nibble
  typedef enum int unsigned {
    BUTTON_UP    = 0,
    BUTTON_DOWN  = 1,
    BUTTON_ONOFF = 2,
    BUTTON_DIR   = 3
  } button_e;

  typedef struct {
    logic [7:0] duty;
    logic [2:0] level;
    logic       reverse;
    logic       over_temp;
  } panel_drive_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic                 cfg_index_i = 1'b0;
  logic [7:0]           cfg_data_i = '0;

  button_motor_power_panel dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predicted panel state and configuration
  logic [3:0]   press_count [4];
  logic         press_armed [4];
  logic         other_free [2];
  logic [2:0]   level_now;
  logic         rotation_now;
  logic [3:0]   debounce_cfg = DEBOUNCE_RST;
  logic [7:0]   threshold_cfg = THRESHOLD_RST;

  logic [InDataW-1:0] sample_queue [$];
  panel_drive_t       expected_drive [$];

  int unsigned beats_queued = 0;
  int unsigned beats_taken = 0;
  int unsigned drives_checked = 0;
  int unsigned cfg_writes = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned holds_asked = 0;
  logic        src_idle_on = 1'b1;
  logic        snk_idle_on = 1'b1;

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one button's debounce qualifier; returns 1 when its action fires
  function automatic logic debounce_step(input button_e b, input logic pin_n);
    logic fire;
    fire = 1'b0;
    if (!pin_n) begin
      if (press_count[b] != 4'hF) press_count[b] = press_count[b] + 4'd1;
      if (press_count[b] >= debounce_cfg) press_armed[b] = 1'b1;
    end else begin
      fire = press_armed[b];
      press_count[b] = '0;
      press_armed[b] = 1'b0;
    end
    return fire;
  endfunction

  // work out the drive after one sample tick and queue it
  task automatic predict_tick(input logic [InDataW-1:0] beat);
    logic         up_n, down_n, onoff_n, dir_n;
    logic [7:0]   temp;
    logic         f_up, f_down, f_onoff, f_dir;
    int unsigned  duty;
    panel_drive_t d;
    up_n    = beat[BUTTON_UP];
    down_n  = beat[BUTTON_DOWN];
    onoff_n = beat[BUTTON_ONOFF];
    dir_n   = beat[BUTTON_DIR];
    temp    = beat[11:4];
    // note whether the other speed button was up when this press began
    if (!up_n && press_count[BUTTON_UP] == 0) other_free[0] = down_n;
    if (!down_n && press_count[BUTTON_DOWN] == 0) other_free[1] = up_n;
    f_up    = debounce_step(BUTTON_UP, up_n) && other_free[0];
    f_down  = debounce_step(BUTTON_DOWN, down_n) && other_free[1];
    f_onoff = debounce_step(BUTTON_ONOFF, onoff_n);
    f_dir   = debounce_step(BUTTON_DIR, dir_n);
    // on/off first, then direction, then speed
    if (f_onoff) level_now = (level_now == 0) ? 3'd1 : 3'd0;
    if (f_dir) rotation_now = ~rotation_now;
    if (level_now > 0) begin
      if (f_up && level_now < TOP_LEVEL) level_now = level_now + 3'd1;
      if (f_down && level_now > 1) level_now = level_now - 3'd1;
    end
    duty = DUTY_PER_LEVEL * level_now;
    if (duty > DUTY_CEILING) duty = DUTY_CEILING;
    d.duty      = duty[7:0];
    d.level     = level_now;
    d.reverse   = rotation_now;
    d.over_temp = (temp > threshold_cfg);
    expected_drive.push_back(d);
  endtask

  // sample beat driver
  int unsigned src_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      src_gap       <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (src_idle_on && src_gap != 0) begin
        s_axis_tvalid <= 1'b0;
        src_gap       <= src_gap - 1;
      end else if (sample_queue.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample_queue.pop_front();
        src_gap       <= src_idle_on ? pick_gap() : 0;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls plus long hold-offs on request
  int unsigned snk_gap;
  int unsigned hold_left;
  int unsigned holds_served;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      snk_gap       <= 0;
      hold_left     <= 0;
      holds_served  <= 0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      holds_served  <= holds_served + 1;
    end else if (snk_idle_on && snk_gap != 0) begin
      m_axis_tready <= 1'b0;
      snk_gap       <= snk_gap - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (snk_idle_on) snk_gap <= pick_gap();
    end
  end

  // accepted sample beats feed the predictor
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predict_tick(s_axis_tdata);
      beats_taken++;
    end
  end

  // result beat checker
  always @(posedge clk_i) begin
    panel_drive_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_drive.size() == 0) begin
        $error("result beat 0x%04h with no sample waiting for it", m_axis_tdata);
        error_count++;
      end else begin
        want = expected_drive.pop_front();
        if (m_axis_tdata[7:0] !== want.duty) begin
          $error("pwm_duty: expected %0d, got %0d", want.duty, m_axis_tdata[7:0]);
          error_count++;
        end
        if (m_axis_tdata[10:8] !== want.level) begin
          $error("power_level: expected %0d, got %0d", want.level, m_axis_tdata[10:8]);
          error_count++;
        end
        if (m_axis_tdata[11] !== want.reverse) begin
          $error("reverse_direction: expected %0d, got %0d", want.reverse, m_axis_tdata[11]);
          error_count++;
        end
        if (m_axis_tdata[12] !== want.over_temp) begin
          $error("over_temperature: expected %0d, got %0d", want.over_temp, m_axis_tdata[12]);
          error_count++;
        end
        if (m_axis_tdata[15:13] !== 3'b000) begin
          $error("padding: expected 0, got %0d", m_axis_tdata[15:13]);
          error_count++;
        end
      end
      drives_checked++;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_drive.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // queue one sample tick: active-low buttons and a temperature
  task automatic add_sample(input logic [3:0] buttons_n, input logic [7:0] temp);
    sample_queue.push_back({4'b0000, temp, buttons_n});
    beats_queued++;
  endtask

  // hold a set of buttons down, then let go
  task automatic press_and_release(input logic [3:0] pressed, input int unsigned hold,
                                   input int unsigned gap);
    repeat (hold) add_sample(~pressed, 8'($urandom));
    repeat (gap) add_sample(ALL_RELEASED, 8'($urandom));
  endtask

  task automatic write_register(input cfg_index_e idx, input logic [7:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_DEBOUNCE:  debounce_cfg = value[3:0];
      CFG_THRESHOLD: threshold_cfg = value;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    cfg_writes++;
  endtask

  task automatic wait_drained();
    while (beats_taken != beats_queued || expected_drive.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // random traffic: mostly whole press/release episodes, some staggered, some noise
  task automatic random_phase(input int unsigned count);
    int unsigned first;
    int unsigned r;
    int unsigned deb;
    logic [3:0]  mask;
    first = beats_queued;
    deb = (debounce_cfg == 0) ? 1 : debounce_cfg;
    while (beats_queued - first < count) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        r = $urandom_range(0, 99);
        if (r < 35) mask = 4'b0001 << BUTTON_UP;
        else if (r < 60) mask = 4'b0001 << BUTTON_DOWN;
        else if (r < 75) mask = 4'b0001 << BUTTON_ONOFF;
        else if (r < 85) mask = 4'b0001 << BUTTON_DIR;
        else mask = 4'($urandom_range(1, 15));
        press_and_release(mask, $urandom_range(1, deb + 3), $urandom_range(1, 3));
      end else if (r < 88) begin
        // one speed button goes down first, the other joins, then one lets go before the other
        mask = $urandom_range(0, 1) ? 4'b0001 : 4'b0010;
        press_and_release(mask, $urandom_range(1, 3), 0);
        press_and_release(4'b0011, $urandom_range(deb, deb + 2), 0);
        press_and_release($urandom_range(0, 1) ? 4'b0001 : 4'b0010, $urandom_range(1, 2),
                          $urandom_range(1, 2));
      end else begin
        repeat ($urandom_range(1, 8)) add_sample(4'($urandom), 8'($urandom));
      end
    end
  endtask

  // stimulus sequence
  initial begin
    for (int i = 0; i < 4; i++) begin
      press_count[i] = '0;
      press_armed[i] = 1'b0;
    end
    other_free[0] = 1'b0;
    other_free[1] = 1'b0;
    level_now     = '0;
    rotation_now  = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed part: single-sample debounce, reset threshold
    write_register(CFG_DEBOUNCE, 8'd1);
    add_sample(4'b1110, 8'd0);      // up while off
    add_sample(4'b1111, 8'd255);    // release: nothing happens
    add_sample(4'b1011, 8'd50);     // on/off
    add_sample(4'b1111, 8'd51);     // level 1
    add_sample(4'b1101, 8'd49);     // down at the floor
    add_sample(4'b1111, 8'd50);
    repeat (5) begin               // climb to the top and one past it
      add_sample(4'b1110, 8'($urandom));
      add_sample(4'b1111, 8'($urandom));
    end
    add_sample(4'b1100, 8'd0);      // both speed buttons together never fire
    add_sample(4'b1111, 8'd255);
    add_sample(4'b0111, 8'd128);    // direction toggle
    add_sample(4'b1111, 8'd127);
    add_sample(4'b0000, 8'd200);    // everything at once: off, reversed back
    add_sample(4'b1111, 8'd1);
    add_sample(4'b1010, 8'd51);     // on/off with up: on, then up sees level 1
    add_sample(4'b1111, 8'd50);
    wait_drained();

    // zero debounce and lowest threshold
    write_register(CFG_DEBOUNCE, 8'd0);
    write_register(CFG_THRESHOLD, 8'd0);
    random_phase(300);
    wait_drained();

    // longest debounce and highest threshold
    write_register(CFG_DEBOUNCE, 8'd15);
    write_register(CFG_THRESHOLD, 8'd255);
    random_phase(340);
    wait_drained();

    // back to reset values (debounce written with spare upper bits); no idling,
    // receiver holds off so the block backs up
    write_register(CFG_DEBOUNCE, 8'hF5);
    write_register(CFG_THRESHOLD, THRESHOLD_RST);
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    holds_asked++;
    random_phase(300);
    wait_drained();

    write_register(CFG_DEBOUNCE, 8'd2);
    write_register(CFG_THRESHOLD, 8'($urandom));
    src_idle_on = 1'b1;
    random_phase(300);
    wait_drained();

    write_register(CFG_DEBOUNCE, 8'd3);
    write_register(CFG_THRESHOLD, 8'h80);
    src_idle_on = 1'b0;
    snk_idle_on = 1'b1;
    random_phase(300);
    wait_drained();

    write_register(CFG_DEBOUNCE, 8'd1);
    write_register(CFG_THRESHOLD, 8'($urandom));
    src_idle_on = 1'b1;
    holds_asked++;
    random_phase(300);
    wait_drained();
    repeat (8) @(posedge clk_i);

    if (expected_drive.size() != 0) begin
      $error("%0d expected results never arrived", expected_drive.size());
      error_count++;
    end
    $display("run: %0d sample beats sent, %0d result beats checked, %0d register writes",
             beats_taken, drives_checked, cfg_writes);
    $display("covered debounce 0 to 15, thresholds 0 to 255, idle and stall mixes, %0d errors",
             error_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
